// ===== rtl/core/cpt_pkg.sv =====
// Shared constants and types for the closest-point-on-triangle core.
package cpt_pkg;

    // Default coordinate format: signed Q8.16.
    localparam int CPT_COORD_WIDTH = 24;
    localparam int CPT_FRAC_BITS   = 16;

    // Code of the feature region that decides the closest point.
    typedef enum logic [2:0] {
        RG_VERT_A   = 3'd0,
        RG_VERT_B   = 3'd1,
        RG_EDGE_AB  = 3'd2,
        RG_VERT_C   = 3'd3,
        RG_EDGE_AC  = 3'd4,
        RG_EDGE_BC  = 3'd5,
        RG_INTERIOR = 3'd6
    } t_region;

endpackage

// ===== rtl/core/cpt_wide_mul.sv =====
// Two-stage signed multiplier built from four half-width partial products.
module cpt_wide_mul
    import cpt_pkg::*;
#(
    parameter int W = 2 * CPT_COORD_WIDTH + 4
) (
    input  logic                  i_clk,
    input  logic signed [W-1:0]   i_a,
    input  logic signed [W-1:0]   i_b,
    output logic signed [2*W-1:0] o_p
);

    localparam int L    = W / 2;
    localparam int H    = W - L;
    localparam int PW   = 2 * W;
    localparam int MIDW = H + L + 2;

    logic signed [H-1:0]     a_h;
    logic signed [H-1:0]     b_h;
    logic signed [L:0]       a_l;
    logic signed [L:0]       b_l;
    logic signed [2*H-1:0]   r_hh;
    logic signed [H+L:0]     r_hl;
    logic signed [H+L:0]     r_lh;
    logic        [2*L-1:0]   r_ll;
    logic signed [MIDW-1:0]  mid;
    logic signed [PW-1:0]    t_hh;
    logic signed [PW-1:0]    t_mid;
    logic signed [PW-1:0]    t_ll;

    // Split each operand into a signed high half and an unsigned low half.
    assign a_h = i_a[W-1:L];
    assign b_h = i_b[W-1:L];
    assign a_l = {1'b0, i_a[L-1:0]};
    assign b_l = {1'b0, i_b[L-1:0]};

    // First stage: the four partial products.
    always_ff @(posedge i_clk) begin
        r_hh <= a_h * b_h;
        r_hl <= a_h * b_l;
        r_lh <= a_l * b_h;
        r_ll <= a_l[L-1:0] * b_l[L-1:0];
    end

    // Align the partial products at full width.
    assign mid   = MIDW'(r_hl) + MIDW'(r_lh);
    assign t_hh  = {r_hh, {(2 * L){1'b0}}};
    assign t_mid = PW'(mid) <<< L;
    assign t_ll  = PW'(r_ll);

    // Second stage: the full product.
    always_ff @(posedge i_clk) begin
        o_p <= t_hh + t_mid + t_ll;
    end

endmodule

// ===== rtl/core/cpt_div.sv =====
// Pipelined restoring divider giving a quotient clamped to [0, 1.0].
module cpt_div
    import cpt_pkg::*;
#(
    parameter int NW        = 4 * CPT_COORD_WIDTH + 11,
    parameter int FRAC_BITS = CPT_FRAC_BITS
) (
    input  logic                 i_clk,
    input  logic signed [NW-1:0] i_num,
    input  logic signed [NW-1:0] i_den,
    output logic [FRAC_BITS:0]   o_quot
);

    localparam int F  = FRAC_BITS;
    localparam int XW = NW + 1;
    localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

    logic signed [XW-1:0] n_num;
    logic signed [XW-1:0] n_den;
    logic [NW-1:0]        r_rem [0:F];
    logic [NW-1:0]        r_dd  [0:F];
    logic [F-1:0]         r_q   [0:F];
    logic                 r_zz  [0:F];
    logic                 r_oo  [0:F];

    // Make the denominator positive by negating both operands.
    always_comb begin
        if (i_den[NW-1]) begin
            n_num = -XW'(i_num);
            n_den = -XW'(i_den);
        end else begin
            n_num = XW'(i_num);
            n_den = XW'(i_den);
        end
    end

    // Entry stage: settle the clamped cases and load the remainder.
    always_ff @(posedge i_clk) begin
        r_zz[0]  <= (i_den == '0) || (n_num <= 0);
        r_oo[0]  <= (n_num >= n_den);
        r_rem[0] <= n_num[NW-1:0];
        r_dd[0]  <= n_den[NW-1:0];
        r_q[0]   <= '0;
    end

    // One quotient bit per stage.
    for (genvar k = 0; k < F; k++) begin : g_step
        logic [NW:0] t_two;
        logic [NW:0] t_dif;

        assign t_two = {r_rem[k], 1'b0};
        assign t_dif = t_two - {1'b0, r_dd[k]};

        always_ff @(posedge i_clk) begin
            if (!t_dif[NW]) begin
                r_rem[k+1] <= t_dif[NW-1:0];
            end else begin
                r_rem[k+1] <= t_two[NW-1:0];
            end
            r_q[k+1]  <= {r_q[k][F-2:0], ~t_dif[NW]};
            r_dd[k+1] <= r_dd[k];
            r_zz[k+1] <= r_zz[k];
            r_oo[k+1] <= r_oo[k];
        end
    end

    // Apply the clamp flags to the finished quotient.
    assign o_quot = r_zz[F] ? '0 : (r_oo[F] ? ONE : {1'b0, r_q[F]});

endmodule

// ===== rtl/core/closest_point_on_triangle_core.sv =====
// Closest point on a triangle to a query point, fully pipelined.
// Throughput: one item per cycle; busy is never raised and the receiver cannot stall.
// The depth is set by the one-bit-per-stage quotient pipeline and the wide determinants.
// Reset clears only the valid bits that travel with each item; payload is not reset.
module closest_point_on_triangle_core
    import cpt_pkg::*;
#(
    parameter int COORD_WIDTH = CPT_COORD_WIDTH,
    parameter int FRAC_BITS   = CPT_FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] i_query_x,
    input  logic signed [COORD_WIDTH-1:0] i_query_y,
    input  logic signed [COORD_WIDTH-1:0] i_query_z,
    input  logic signed [COORD_WIDTH-1:0] i_vert_a_x,
    input  logic signed [COORD_WIDTH-1:0] i_vert_a_y,
    input  logic signed [COORD_WIDTH-1:0] i_vert_a_z,
    input  logic signed [COORD_WIDTH-1:0] i_vert_b_x,
    input  logic signed [COORD_WIDTH-1:0] i_vert_b_y,
    input  logic signed [COORD_WIDTH-1:0] i_vert_b_z,
    input  logic signed [COORD_WIDTH-1:0] i_vert_c_x,
    input  logic signed [COORD_WIDTH-1:0] i_vert_c_y,
    input  logic signed [COORD_WIDTH-1:0] i_vert_c_z,
    output logic                          o_done,
    output logic signed [COORD_WIDTH-1:0] o_near_x,
    output logic signed [COORD_WIDTH-1:0] o_near_y,
    output logic signed [COORD_WIDTH-1:0] o_near_z,
    output logic [FRAC_BITS:0]            o_weight_a,
    output logic [FRAC_BITS:0]            o_weight_b,
    output logic [FRAC_BITS:0]            o_weight_c,
    output logic [2*COORD_WIDTH+1:0]      o_dist_squared,
    output logic [2:0]                    o_region
);

    localparam int CW     = COORD_WIDTH;
    localparam int F      = FRAC_BITS;
    localparam int DFW    = CW + 1;
    localparam int PW     = 2 * DFW;
    localparam int DW     = PW + 2;
    localparam int EW     = DW + 1;
    localparam int VW     = 2 * DW + 1;
    localparam int NW     = VW + 2;
    localparam int MW     = F + DFW + 2;
    localparam int SMW    = CW + 3;
    localparam int DIST_W = 2 * CW + 2;
    localparam int SW     = DIST_W + 2;
    localparam int PTS_W  = 12 * CW;
    localparam int DIV_ST = F + 8;
    localparam int LAT    = F + 14;
    localparam logic [F:0]   ONE   = {1'b1, {F{1'b0}}};
    localparam logic [F+2:0] ONE_X = {2'b00, ONE};

    logic                   accept;
    logic [PTS_W-1:0]       in_pts;
    logic signed [CW-1:0]   in_p [3];
    logic signed [CW-1:0]   in_a [3];
    logic signed [CW-1:0]   in_b [3];
    logic signed [CW-1:0]   in_c [3];

    logic                   r_vld [1:LAT];
    logic [PTS_W-1:0]       r_pts [1:DIV_ST];

    logic signed [DFW-1:0]  r1_ab [3];
    logic signed [DFW-1:0]  r1_ac [3];
    logic signed [DFW-1:0]  r1_ap [3];
    logic signed [DFW-1:0]  r1_bp [3];
    logic signed [DFW-1:0]  r1_cp [3];
    logic signed [PW-1:0]   r2_prod [6][3];
    logic signed [DW-1:0]   r_d [3:6][6];
    logic signed [2*DW-1:0] mp [6];
    logic signed [VW-1:0]   r6_va;
    logic signed [VW-1:0]   r6_vb;
    logic signed [VW-1:0]   r6_vc;

    logic signed [DW-1:0]   d1, d2, d3, d4, d5, d6;
    logic signed [EW-1:0]   n_e43;
    logic signed [EW-1:0]   n_e56;
    logic signed [NW-1:0]   n_den_i;
    logic signed [NW-1:0]   n_nv, n_dv, n_nw, n_dw;
    t_region                n_rg;
    logic signed [NW-1:0]   r7_nv, r7_dv, r7_nw, r7_dw;
    t_region                r_rg [7:DIV_ST];

    logic [F:0]             q_v;
    logic [F:0]             q_w;

    logic signed [CW-1:0]   u_p [3];
    logic signed [CW-1:0]   u_a [3];
    logic signed [CW-1:0]   u_b [3];
    logic signed [CW-1:0]   u_c [3];
    logic [F+1:0]           vw_sum;
    logic [F:0]             w_adj;
    logic [F:0]             n_wa, n_wb, n_wc, n_t1, n_t2;
    logic signed [DFW-1:0]  n_dl1 [3];
    logic signed [DFW-1:0]  n_dl2 [3];
    logic signed [CW-1:0]   n_base [3];

    logic [F:0]             r_wa [0:5];
    logic [F:0]             r_wb [0:5];
    logic [F:0]             r_wc [0:5];
    t_region                r_rg2 [0:5];
    logic [F:0]             r9_t1, r9_t2;
    logic signed [DFW-1:0]  r9_dl1 [3];
    logic signed [DFW-1:0]  r9_dl2 [3];
    logic signed [CW-1:0]   r9_base [3];
    logic signed [CW-1:0]   r9_p [3];
    logic signed [MW-1:0]   r10_m1 [3];
    logic signed [MW-1:0]   r10_m2 [3];
    logic signed [CW-1:0]   r10_base [3];
    logic signed [CW-1:0]   r10_p [3];
    logic signed [SMW-1:0]  n_sum [3];
    logic signed [CW-1:0]   n_q [3];
    logic signed [CW-1:0]   r_nq [0:3][3];
    logic signed [CW-1:0]   r11_p [3];
    logic signed [DFW-1:0]  r12_dq [3];
    logic signed [PW-1:0]   r13_sq [3];
    logic [SW-1:0]          n_dsum;
    logic [DIST_W-1:0]      r14_dist;

    // The pipeline takes an item in every cycle.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign in_p[0] = i_query_x;
    assign in_p[1] = i_query_y;
    assign in_p[2] = i_query_z;
    assign in_a[0] = i_vert_a_x;
    assign in_a[1] = i_vert_a_y;
    assign in_a[2] = i_vert_a_z;
    assign in_b[0] = i_vert_b_x;
    assign in_b[1] = i_vert_b_y;
    assign in_b[2] = i_vert_b_z;
    assign in_c[0] = i_vert_c_x;
    assign in_c[1] = i_vert_c_y;
    assign in_c[2] = i_vert_c_z;
    assign in_pts  = {i_vert_c_z, i_vert_c_y, i_vert_c_x, i_vert_b_z, i_vert_b_y, i_vert_b_x,
                      i_vert_a_z, i_vert_a_y, i_vert_a_x, i_query_z, i_query_y, i_query_x};

    // Valid bits travel alongside each item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 1; s <= LAT; s++) r_vld[s] <= 1'b0;
        end else begin
            r_vld[1] <= accept;
            for (int s = 2; s <= LAT; s++) r_vld[s] <= r_vld[s-1];
        end
    end

    // The input points ride along until the quotients are done.
    always_ff @(posedge i_clk) begin
        r_pts[1] <= in_pts;
        for (int s = 2; s <= DIV_ST; s++) r_pts[s] <= r_pts[s-1];
    end

    // Stage 1: edge and offset vectors.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r1_ab[k] <= DFW'(in_b[k]) - DFW'(in_a[k]);
            r1_ac[k] <= DFW'(in_c[k]) - DFW'(in_a[k]);
            r1_ap[k] <= DFW'(in_p[k]) - DFW'(in_a[k]);
            r1_bp[k] <= DFW'(in_p[k]) - DFW'(in_b[k]);
            r1_cp[k] <= DFW'(in_p[k]) - DFW'(in_c[k]);
        end
    end

    // Stage 2: per-axis products of the six dot products.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r2_prod[0][k] <= r1_ab[k] * r1_ap[k];
            r2_prod[1][k] <= r1_ac[k] * r1_ap[k];
            r2_prod[2][k] <= r1_ab[k] * r1_bp[k];
            r2_prod[3][k] <= r1_ac[k] * r1_bp[k];
            r2_prod[4][k] <= r1_ab[k] * r1_cp[k];
            r2_prod[5][k] <= r1_ac[k] * r1_cp[k];
        end
    end

    // Stage 3: dot products d1 to d6, then held until the region decision.
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 6; j++) begin
            r_d[3][j] <= DW'(r2_prod[j][0]) + DW'(r2_prod[j][1]) + DW'(r2_prod[j][2]);
            for (int s = 4; s <= 6; s++) r_d[s][j] <= r_d[s-1][j];
        end
    end

    // Stages 4 and 5: the six products of the 2x2 determinants.
    cpt_wide_mul #(.W(DW)) u_mul_0 (.i_clk(i_clk), .i_a(r_d[3][0]), .i_b(r_d[3][3]), .o_p(mp[0]));
    cpt_wide_mul #(.W(DW)) u_mul_1 (.i_clk(i_clk), .i_a(r_d[3][2]), .i_b(r_d[3][1]), .o_p(mp[1]));
    cpt_wide_mul #(.W(DW)) u_mul_2 (.i_clk(i_clk), .i_a(r_d[3][4]), .i_b(r_d[3][1]), .o_p(mp[2]));
    cpt_wide_mul #(.W(DW)) u_mul_3 (.i_clk(i_clk), .i_a(r_d[3][0]), .i_b(r_d[3][5]), .o_p(mp[3]));
    cpt_wide_mul #(.W(DW)) u_mul_4 (.i_clk(i_clk), .i_a(r_d[3][2]), .i_b(r_d[3][5]), .o_p(mp[4]));
    cpt_wide_mul #(.W(DW)) u_mul_5 (.i_clk(i_clk), .i_a(r_d[3][4]), .i_b(r_d[3][3]), .o_p(mp[5]));

    // Stage 6: the barycentric determinants va, vb and vc.
    always_ff @(posedge i_clk) begin
        r6_vc <= VW'(mp[0]) - VW'(mp[1]);
        r6_vb <= VW'(mp[2]) - VW'(mp[3]);
        r6_va <= VW'(mp[4]) - VW'(mp[5]);
    end

    assign d1 = r_d[6][0];
    assign d2 = r_d[6][1];
    assign d3 = r_d[6][2];
    assign d4 = r_d[6][3];
    assign d5 = r_d[6][4];
    assign d6 = r_d[6][5];

    // Stage 7: region tests in priority order and the operands of both quotients.
    always_comb begin
        n_e43   = EW'(d4) - EW'(d3);
        n_e56   = EW'(d5) - EW'(d6);
        n_den_i = NW'(r6_va) + NW'(r6_vb) + NW'(r6_vc);
        n_nv    = NW'(r6_vb);
        n_dv    = n_den_i;
        n_nw    = NW'(r6_vc);
        n_dw    = n_den_i;
        if (d1 <= 0 && d2 <= 0) begin
            n_rg = RG_VERT_A;
        end else if (d3 >= 0 && d4 <= d3) begin
            n_rg = RG_VERT_B;
        end else if (r6_vc <= 0 && d1 >= 0 && d3 <= 0) begin
            n_rg = RG_EDGE_AB;
            n_nv = NW'(d1);
            n_dv = NW'(d1) - NW'(d3);
        end else if (d6 >= 0 && d5 <= d6) begin
            n_rg = RG_VERT_C;
        end else if (r6_vb <= 0 && d2 >= 0 && d6 <= 0) begin
            n_rg = RG_EDGE_AC;
            n_nw = NW'(d2);
            n_dw = NW'(d2) - NW'(d6);
        end else if (r6_va <= 0 && n_e43 >= 0 && n_e56 >= 0) begin
            n_rg = RG_EDGE_BC;
            n_nw = NW'(n_e43);
            n_dw = NW'(n_e43) + NW'(n_e56);
        end else begin
            n_rg = RG_INTERIOR;
        end
    end

    always_ff @(posedge i_clk) begin
        r7_nv <= n_nv;
        r7_dv <= n_dv;
        r7_nw <= n_nw;
        r7_dw <= n_dw;
        r_rg[7] <= n_rg;
        for (int s = 8; s <= DIV_ST; s++) r_rg[s] <= r_rg[s-1];
    end

    // Two quotient lanes: v (edge AB, interior) and w (edges AC and BC, interior).
    cpt_div #(.NW(NW), .FRAC_BITS(F)) u_div_v (
        .i_clk  (i_clk),
        .i_num  (r7_nv),
        .i_den  (r7_dv),
        .o_quot (q_v)
    );

    cpt_div #(.NW(NW), .FRAC_BITS(F)) u_div_w (
        .i_clk  (i_clk),
        .i_num  (r7_nw),
        .i_den  (r7_dw),
        .o_quot (q_w)
    );

    // Unpack the points that left the pipeline with the quotients.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            u_p[k] = r_pts[DIV_ST][k*CW +: CW];
            u_a[k] = r_pts[DIV_ST][(3+k)*CW +: CW];
            u_b[k] = r_pts[DIV_ST][(6+k)*CW +: CW];
            u_c[k] = r_pts[DIV_ST][(9+k)*CW +: CW];
        end
    end

    // Weights, base point and interpolation terms for each region.
    always_comb begin
        vw_sum = {1'b0, q_v} + {1'b0, q_w};
        w_adj  = (vw_sum > {1'b0, ONE}) ? (ONE - q_v) : q_w;
        n_wa   = ONE;
        n_wb   = '0;
        n_wc   = '0;
        n_t1   = '0;
        n_t2   = '0;
        for (int k = 0; k < 3; k++) begin
            n_base[k] = u_a[k];
            n_dl1[k]  = DFW'(u_b[k]) - DFW'(u_a[k]);
            n_dl2[k]  = DFW'(u_c[k]) - DFW'(u_a[k]);
        end
        case (r_rg[DIV_ST])
            RG_VERT_B: begin
                n_wa = '0;
                n_wb = ONE;
                for (int k = 0; k < 3; k++) n_base[k] = u_b[k];
            end
            RG_EDGE_AB: begin
                n_wa = ONE - q_v;
                n_wb = q_v;
                n_t1 = q_v;
            end
            RG_VERT_C: begin
                n_wa = '0;
                n_wc = ONE;
                for (int k = 0; k < 3; k++) n_base[k] = u_c[k];
            end
            RG_EDGE_AC: begin
                n_wa = ONE - q_w;
                n_wc = q_w;
                n_t1 = q_w;
                for (int k = 0; k < 3; k++) n_dl1[k] = DFW'(u_c[k]) - DFW'(u_a[k]);
            end
            RG_EDGE_BC: begin
                n_wa = '0;
                n_wb = ONE - q_w;
                n_wc = q_w;
                n_t1 = q_w;
                for (int k = 0; k < 3; k++) begin
                    n_base[k] = u_b[k];
                    n_dl1[k]  = DFW'(u_c[k]) - DFW'(u_b[k]);
                end
            end
            RG_INTERIOR: begin
                n_wa = ONE - q_v - w_adj;
                n_wb = q_v;
                n_wc = w_adj;
                n_t1 = q_v;
                n_t2 = w_adj;
            end
            default: begin
                n_wa = ONE;
            end
        endcase
    end

    // Stage F+9: register weights and interpolation operands.
    always_ff @(posedge i_clk) begin
        r9_t1 <= n_t1;
        r9_t2 <= n_t2;
        for (int k = 0; k < 3; k++) begin
            r9_dl1[k]  <= n_dl1[k];
            r9_dl2[k]  <= n_dl2[k];
            r9_base[k] <= n_base[k];
            r9_p[k]    <= u_p[k];
        end
        r_wa[0]  <= n_wa;
        r_wb[0]  <= n_wb;
        r_wc[0]  <= n_wc;
        r_rg2[0] <= r_rg[DIV_ST];
        for (int s = 1; s <= 5; s++) begin
            r_wa[s]  <= r_wa[s-1];
            r_wb[s]  <= r_wb[s-1];
            r_wc[s]  <= r_wc[s-1];
            r_rg2[s] <= r_rg2[s-1];
        end
    end

    // Stage F+10: scale the edge vectors by the quotients.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r10_m1[k]   <= $signed({1'b0, r9_t1}) * r9_dl1[k];
            r10_m2[k]   <= $signed({1'b0, r9_t2}) * r9_dl2[k];
            r10_base[k] <= r9_base[k];
            r10_p[k]    <= r9_p[k];
        end
    end

    // Stage F+11: floor the scaled terms, add to the base and saturate.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_sum[k] = SMW'(r10_base[k]) + SMW'(r10_m1[k] >>> F) + SMW'(r10_m2[k] >>> F);
            if (!n_sum[k][SMW-1] && (n_sum[k][SMW-2:CW-1] != '0)) begin
                n_q[k] = {1'b0, {(CW - 1){1'b1}}};
            end else if (n_sum[k][SMW-1] && (n_sum[k][SMW-2:CW-1] != '1)) begin
                n_q[k] = {1'b1, {(CW - 1){1'b0}}};
            end else begin
                n_q[k] = n_sum[k][CW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_nq[0][k] <= n_q[k];
            r11_p[k]   <= r10_p[k];
            for (int s = 1; s <= 3; s++) r_nq[s][k] <= r_nq[s-1][k];
        end
    end

    // Stages F+12 and F+13: offset to the query point and its squares.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r12_dq[k] <= DFW'(r11_p[k]) - DFW'(r_nq[0][k]);
            r13_sq[k] <= r12_dq[k] * r12_dq[k];
        end
    end

    // Stage F+14: squared distance with saturation.
    assign n_dsum = SW'(r13_sq[0]) + SW'(r13_sq[1]) + SW'(r13_sq[2]);

    always_ff @(posedge i_clk) begin
        if (n_dsum[SW-1:DIST_W] != '0) begin
            r14_dist <= '1;
        end else begin
            r14_dist <= n_dsum[DIST_W-1:0];
        end
    end

    assign o_done         = r_vld[LAT];
    assign o_near_x       = r_nq[3][0];
    assign o_near_y       = r_nq[3][1];
    assign o_near_z       = r_nq[3][2];
    assign o_weight_a     = r_wa[5];
    assign o_weight_b     = r_wb[5];
    assign o_weight_c     = r_wc[5];
    assign o_dist_squared = r14_dist;
    assign o_region       = r_rg2[5];

`ifndef SYNTHESIS
    // Each result must match an item that was taken the full pipeline latency earlier.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, LAT))
        else $error("result without an item accepted one latency earlier");

    // The weights of every result sum to exactly one.
    a_weight_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ((o_weight_a + o_weight_b + o_weight_c) == ONE_X))
        else $error("barycentric weights do not sum to one");

    // A vertex B result puts all weight on B.
    a_vert_b: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_region == RG_VERT_B) |-> (o_weight_b == ONE && o_weight_a == '0))
        else $error("vertex B region with wrong weights");
`endif

endmodule
